// ===== rtl/core/pfbe_pkg.sv =====
// Shared constants, opcodes and the command record for the page framebuffer blit engine.
package pfbe_pkg;

	localparam int COLUMNS     = 128;
	localparam int ROWS        = 64;
	localparam int MAX_HEIGHT  = 32;
	localparam int PAGES       = ROWS / 8;
	localparam int STORE_BYTES = COLUMNS * PAGES;
	localparam int HEIGHT_LIM  = (MAX_HEIGHT < ROWS) ? MAX_HEIGHT : ROWS;

	localparam int COL_W   = $clog2(COLUMNS);
	localparam int PAGE_W  = $clog2(PAGES);
	localparam int ADDR_W  = $clog2(STORE_BYTES);
	localparam int SPAN_W  = MAX_HEIGHT + 7;
	localparam int SPAN_PG = (SPAN_W + 7) / 8;
	localparam int LANE_W  = SPAN_PG * 8;
	localparam int NP_W    = $clog2(SPAN_PG + 1);

	localparam int QUEUE_DEPTH = 4;
	localparam int QP_W        = $clog2(QUEUE_DEPTH);

	localparam int IN_W  = 72;
	localparam int OUT_W = 16;

	typedef enum logic [2:0] {
		OP_SET   = 3'd0,
		OP_CLR   = 3'd1,
		OP_FILL  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_BLIT  = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		K_NONE,
		K_RMW,
		K_SWEEP,
		K_READ
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic                 done;
		logic [COL_W-1:0]     col;
		logic [PAGE_W-1:0]    page;
		logic [NP_W-1:0]      npages;
		logic [LANE_W-1:0]    val;
		logic [LANE_W-1:0]    mask;
		logic                 replace;
	} cmd_t;

endpackage

// ===== rtl/core/pfbe_front.sv =====
// Front end: unpacks an input item and classifies it into a command record.
module pfbe_front (
	input  logic [pfbe_pkg::IN_W-1:0] tdata,
	output pfbe_pkg::cmd_t            cmd
);
	import pfbe_pkg::*;

	logic [2:0]  op;
	logic [6:0]  x;
	logic [5:0]  y;
	logic [7:0]  width;
	logic [5:0]  height;
	logic [6:0]  cidx;
	logic [31:0] bits;
	logic        ow;

	assign op     = tdata[2:0];
	assign x      = tdata[9:3];
	assign y      = tdata[15:10];
	assign width  = tdata[23:16];
	assign height = tdata[29:24];
	assign cidx   = tdata[36:30];
	assign bits   = tdata[68:37];
	assign ow     = tdata[69];

	always_comb begin
		logic [7:0]            w;
		logic [5:0]            h;
		logic [7:0]            lim_x;
		logic [7:0]            cx;
		logic [7:0]            col8;
		logic [6:0]            lim_y;
		logic [6:0]            cy;
		logic [6:0]            last_row;
		logic [MAX_HEIGHT-1:0] rmask;
		logic [LANE_W-1:0]     pmask;
		logic                  on_screen;
		logic                  skip;

		w         = (width > 8'(COLUMNS)) ? 8'(COLUMNS) : width;
		h         = (height > 6'(HEIGHT_LIM)) ? 6'(HEIGHT_LIM) : height;
		lim_x     = 8'(COLUMNS) - w;
		cx        = ({1'b0, x} > lim_x) ? lim_x : {1'b0, x};
		col8      = cx + {1'b0, cidx};
		lim_y     = 7'(ROWS) - {1'b0, h};
		cy        = ({1'b0, y} > lim_y) ? lim_y : {1'b0, y};
		last_row  = cy + {1'b0, h} - 7'd1;
		rmask     = MAX_HEIGHT'(((MAX_HEIGHT+1)'(1)) << h) - MAX_HEIGHT'(1);
		skip      = (w == 8'd0) || (h == 6'd0) || ({1'b0, cidx} >= w) ||
		            (col8 >= 8'(COLUMNS));
		on_screen = ({1'b0, x} < 8'(COLUMNS)) && ({1'b0, y} < 7'(ROWS));
		pmask     = LANE_W'(1) << y[2:0];

		cmd         = '0;
		cmd.kind    = K_NONE;
		cmd.done    = 1'b1;
		cmd.col     = COL_W'(x);
		cmd.page    = PAGE_W'(y >> 3);
		cmd.npages  = NP_W'(1);
		cmd.replace = 1'b1;

		case (op)
			OP_SET, OP_CLR: begin
				if (on_screen) begin
					cmd.kind = K_RMW;
					cmd.mask = pmask;
					cmd.val  = (op == OP_SET) ? pmask : '0;
				end
			end
			OP_FILL: begin
				cmd.kind = K_SWEEP;
				cmd.val  = LANE_W'(8'hFF);
			end
			OP_CLEAR: begin
				cmd.kind = K_SWEEP;
			end
			OP_BLIT: begin
				if (!skip) begin
					cmd.kind    = K_RMW;
					cmd.col     = COL_W'(col8);
					cmd.page    = PAGE_W'(cy >> 3);
					cmd.npages  = NP_W'((last_row >> 3) - (cy >> 3) + 7'd1);
					cmd.val     = LANE_W'(bits & rmask) << cy[2:0];
					cmd.mask    = LANE_W'(rmask) << cy[2:0];
					cmd.replace = ow;
				end
			end
			OP_READ: begin
				if (on_screen) cmd.kind = K_READ;
			end
			default: begin
				cmd.done = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/core/pfbe_queue.sv =====
// Short command queue between the front end and the execution back end.
module pfbe_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfbe_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output pfbe_pkg::cmd_t head
);
	import pfbe_pkg::*;

	cmd_t            slot_q [QUEUE_DEPTH];
	logic [QP_W-1:0] wr_q;
	logic [QP_W-1:0] rd_q;
	logic [QP_W:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == (QP_W+1)'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign head    = slot_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + QP_W'(1);
			if (do_pop)  rd_q <= rd_q + QP_W'(1);
			if (do_push && !do_pop)      count_q <= count_q + (QP_W+1)'(1);
			else if (do_pop && !do_push) count_q <= count_q - (QP_W+1)'(1);
		end
	end

endmodule

// ===== rtl/core/pfbe_back.sv =====
// Back end: framebuffer memory, fill and clear sweeps, page read-modify-write and the result register.
module pfbe_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  pfbe_pkg::cmd_t             cmd,
	output logic                       cmd_pop,
	output logic                       init_busy,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pfbe_pkg::OUT_W-1:0] out_data
);
	import pfbe_pkg::*;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SWEEP,
		ST_RD,
		ST_WR
	} state_t;

	state_t            state_q;
	cmd_t              cmd_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [7:0]        fill_q;
	logic [PAGE_W-1:0] page_q;
	logic [NP_W-1:0]   left_q;
	logic              out_valid_q;
	logic [7:0]        out_rd_q;
	logic              out_done_q;

	logic [7:0]        mem_q [STORE_BYTES];
	logic [7:0]        rd_data_q;
	logic              sweeping;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        mem_wd;
	logic [7:0]        merged;

	assign sweeping  = (state_q == ST_INIT) || (state_q == ST_SWEEP);
	assign merged    = cmd_q.replace ? ((rd_data_q & ~cmd_q.mask[7:0]) | cmd_q.val[7:0]) :
	                                   (rd_data_q | cmd_q.val[7:0]);
	assign mem_we    = sweeping || ((state_q == ST_WR) && (cmd_q.kind == K_RMW));
	assign mem_re    = (state_q == ST_RD);
	assign mem_addr  = sweeping ? sweep_q : {page_q, cmd_q.col};
	assign mem_wd    = sweeping ? fill_q : merged;
	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid && !out_valid_q;
	assign init_busy = (state_q == ST_INIT);
	assign out_valid = out_valid_q;
	assign out_data  = {(OUT_W-9)'(0), out_done_q, out_rd_q};

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_addr] <= mem_wd;
		if (mem_re) rd_data_q <= mem_q[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cmd_q       <= '0;
			sweep_q     <= '0;
			fill_q      <= '0;
			page_q      <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
			out_rd_q    <= '0;
			out_done_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == ADDR_W'(STORE_BYTES - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_pop) begin
						cmd_q  <= cmd;
						page_q <= cmd.page;
						left_q <= cmd.npages;
						case (cmd.kind)
							K_SWEEP: begin
								sweep_q <= '0;
								fill_q  <= cmd.val[7:0];
								state_q <= ST_SWEEP;
							end
							K_RMW, K_READ: state_q <= ST_RD;
							default: begin
								out_valid_q <= 1'b1;
								out_rd_q    <= '0;
								out_done_q  <= cmd.done;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + ADDR_W'(1);
					if (sweep_q == ADDR_W'(STORE_BYTES - 1)) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_rd_q    <= '0;
						out_done_q  <= 1'b1;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (cmd_q.kind == K_READ || left_q == NP_W'(1)) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
						out_rd_q    <= (cmd_q.kind == K_READ) ? rd_data_q : 8'd0;
						out_done_q  <= 1'b1;
					end else begin
						state_q <= ST_RD;
					end
					cmd_q.val  <= cmd_q.val >> 8;
					cmd_q.mask <= cmd_q.mask >> 8;
					page_q     <= page_q + PAGE_W'(1);
					left_q     <= left_q - NP_W'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/page_framebuffer_blit_engine.sv =====
// Top level of the page framebuffer blit engine: front end, command queue and back end.
// Usage:
//   Commands enter on the s_ stream (one item per command) and each gives exactly one
//   result item on the m_ stream, in order. The framebuffer is 8 pages of 128 column
//   bytes held in a single-port-write, registered-read memory.
//   The front end decodes an item in the cycle it is accepted and queues it (4 deep),
//   so s_tready stays high while the back end works or a result waits, until the
//   queue fills.
//   The back end takes one command at a time from the queue, and the next one only
//   after the result has left the output register. Per command it does:
//     unknown or no-effect command   result register loaded directly
//     set/clear pixel, read byte     one memory read, then one write (none for a read)
//     blit column                    one read then one write per page (pages 1..5)
//     fill / clear all               all 1024 bytes, one byte written per cycle
//   After reset the memory is swept to zero; s_tready is low until the sweep ends.
//   When the receiver holds m_tready low the result stays in the output register,
//   the back end waits and the queue keeps taking items until full.
module page_framebuffer_blit_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// operation[2:0], x[9:3], y[15:10], width[23:16], height[29:24],
	// column_index[36:30], column_bits[68:37], overwrite[69], zero[71:70]
	input  logic [pfbe_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// read_data[7:0], op_done[8], zero[15:9]
	output logic [pfbe_pkg::OUT_W-1:0] m_tdata
);
	import pfbe_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic q_full;
	logic q_valid;
	logic q_pop;
	logic init_busy;

	assign s_tready = !q_full && !init_busy;

	pfbe_front u_front (
		.tdata (s_tdata),
		.cmd   (front_cmd)
	);

	pfbe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (s_tvalid && s_tready),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head_cmd)
	);

	pfbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.init_busy (init_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
